[src/wpd_pkg.sv]
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared widths, constants, register indexes, controller states and the
// command/status bundles of the window peak AC/DC detector.
// ----------------------------------------------------------------------------
package wpd_pkg;

    localparam int ADC_W      = 10;
    localparam int MV_W       = 13;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 16;
    localparam int PROD_W     = 24;

    localparam int WINDOW_LEN_DEF = 10;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CAP_MS = 2'd1;

    localparam logic [CFG_W-1:0] STEP_MS_RST      = 10'd5;
    localparam logic [CFG_W-1:0] TIMER_CAP_MS_RST = 10'd999;

    localparam logic [12:0]        MV_SCALE   = 13'd5000;
    localparam logic [PROD_W-1:0]  MV_OFFSET  = 24'd2560000;
    localparam logic [PROD_W-1:0]  DIV_ROUND  = 24'd1023;
    localparam int                 DIV_SHIFT  = 10;

    localparam logic signed [MV_W-1:0] MV_MIN = 13'sh1000;
    localparam logic signed [MV_W-1:0] MV_MAX = 13'sh0FFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } wpd_state_t;

    typedef struct packed {
        logic load_sample;
        logic convert;
        logic update;
        logic scan;
        logic load_out;
    } wpd_cmd_t;

    typedef struct packed {
        logic out_full;
    } wpd_status_t;

endpackage

[src/window_peak_ac_dc_detector.sv]
// ----------------------------------------------------------------------------
// window_peak_ac_dc_detector
// A beat is converted, shifted into the window and followed by a min/max scan
// over the window, one entry per cycle; the result then goes to the output
// register. No new beat is taken until that result has been loaded there.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, aresetn low): window, timer and count cleared to zero,
// step_ms = 5, timer_cap_ms = 999, no result pending.
// ----------------------------------------------------------------------------
module window_peak_ac_dc_detector #(
    parameter int WINDOW_LEN = wpd_pkg::WINDOW_LEN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [wpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wpd_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [wpd_pkg::ADC_W-1:0]             s_adc_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [wpd_pkg::MV_W-1:0]       m_sample_mv,
    output logic signed [wpd_pkg::MV_W-1:0]       m_peak_mv,
    output logic                                  m_is_dc,
    output logic [wpd_pkg::CFG_W-1:0]             m_ms_since_crossing,
    output logic [wpd_pkg::COUNT_W-1:0]           m_sample_count
);

    wpd_pkg::wpd_cmd_t    cmd;
    wpd_pkg::wpd_status_t status;

    wpd_ctrl #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wpd_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_adc_sample        (s_adc_sample),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_sample_mv         (m_sample_mv),
        .m_peak_mv           (m_peak_mv),
        .m_is_dc             (m_is_dc),
        .m_ms_since_crossing (m_ms_since_crossing),
        .m_sample_count      (m_sample_count),
        .cmd                 (cmd),
        .status              (status)
    );

endmodule

[src/wpd_ctrl.sv]
// ----------------------------------------------------------------------------
// wpd_ctrl
// Sequencer: takes a beat, steps conversion, window update and the scan over
// the window, then hands the result to the output register.
// ----------------------------------------------------------------------------
module wpd_ctrl #(
    parameter int WINDOW_LEN = wpd_pkg::WINDOW_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 m_ready,
    input  wpd_pkg::wpd_status_t status,
    output wpd_pkg::wpd_cmd_t    cmd
);

    localparam int SCAN_W = $clog2(WINDOW_LEN);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(WINDOW_LEN - 1);

    wpd_pkg::wpd_state_t state_reg, state_next;
    logic [SCAN_W-1:0]   scan_cnt_reg, scan_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wpd_pkg::ST_IDLE;
            scan_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            wpd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = wpd_pkg::ST_CONV;
                end
            end
            wpd_pkg::ST_CONV: begin
                cmd.convert = 1'b1;
                state_next  = wpd_pkg::ST_UPDATE;
            end
            wpd_pkg::ST_UPDATE: begin
                cmd.update    = 1'b1;
                scan_cnt_next = '0;
                state_next    = wpd_pkg::ST_SCAN;
            end
            wpd_pkg::ST_SCAN: begin
                cmd.scan      = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_LAST) begin
                    state_next = wpd_pkg::ST_DONE;
                end
            end
            wpd_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!status.out_full || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = wpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wpd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/wpd_datapath.sv]
// ----------------------------------------------------------------------------
// wpd_datapath
// Millivolt conversion, sample window, crossing timer, sample counter,
// min/max scan over the window and the output register.
// ----------------------------------------------------------------------------
module wpd_datapath #(
    parameter int WINDOW_LEN = wpd_pkg::WINDOW_LEN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [wpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wpd_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic [wpd_pkg::ADC_W-1:0]             s_adc_sample,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic signed [wpd_pkg::MV_W-1:0]       m_sample_mv,
    output logic signed [wpd_pkg::MV_W-1:0]       m_peak_mv,
    output logic                                  m_is_dc,
    output logic [wpd_pkg::CFG_W-1:0]             m_ms_since_crossing,
    output logic [wpd_pkg::COUNT_W-1:0]           m_sample_count,
    input  wpd_pkg::wpd_cmd_t                     cmd,
    output wpd_pkg::wpd_status_t                  status
);

    localparam int MV_W  = wpd_pkg::MV_W;
    localparam int CFG_W = wpd_pkg::CFG_W;

    logic [CFG_W-1:0]              step_ms_reg;
    logic [CFG_W-1:0]              timer_cap_ms_reg;
    logic [wpd_pkg::ADC_W-1:0]     sample_reg;
    logic signed [MV_W-1:0]        mv_reg;
    logic signed [MV_W-1:0]        win_reg [WINDOW_LEN];
    logic [CFG_W-1:0]              timer_reg, timer_next;
    logic [wpd_pkg::COUNT_W-1:0]   count_reg;
    logic signed [MV_W-1:0]        hi_reg, lo_reg;

    logic                          m_valid_reg;
    logic signed [MV_W-1:0]        out_mv_reg, out_peak_reg;
    logic                          out_dc_reg;
    logic [CFG_W-1:0]              out_timer_reg;
    logic [wpd_pkg::COUNT_W-1:0]   out_count_reg;

    logic [wpd_pkg::PROD_W-1:0]    prod;
    logic [wpd_pkg::PROD_W-1:0]    num;
    logic [wpd_pkg::PROD_W-1:0]    num_adj;
    logic signed [MV_W-1:0]        mv_next;
    logic [CFG_W:0]                timer_sum;
    logic                          rising;

    // trunc((5000*s - 2560000) / 1024), rounding toward zero
    always_comb begin
        prod    = wpd_pkg::PROD_W'(wpd_pkg::MV_SCALE) * wpd_pkg::PROD_W'(sample_reg);
        num     = prod - wpd_pkg::MV_OFFSET;
        num_adj = num[wpd_pkg::PROD_W-1] ? (num + wpd_pkg::DIV_ROUND) : num;
        mv_next = MV_W'($signed(num_adj) >>> wpd_pkg::DIV_SHIFT);
    end

    always_comb begin
        rising    = win_reg[WINDOW_LEN-1][MV_W-1] && !mv_reg[MV_W-1];
        timer_sum = {1'b0, timer_reg} + {1'b0, step_ms_reg};
        if (rising) begin
            timer_next = '0;
        end else if (timer_sum > {1'b0, timer_cap_ms_reg}) begin
            timer_next = timer_cap_ms_reg;
        end else begin
            timer_next = timer_sum[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ms_reg      <= wpd_pkg::STEP_MS_RST;
            timer_cap_ms_reg <= wpd_pkg::TIMER_CAP_MS_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == wpd_pkg::REG_STEP_MS) begin
                step_ms_reg <= cfg_wdata;
            end
            if (cfg_index == wpd_pkg::REG_TIMER_CAP_MS) begin
                timer_cap_ms_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_adc_sample;
        end
        if (cmd.convert) begin
            mv_reg <= mv_next;
        end
        if (cmd.update) begin
            hi_reg <= wpd_pkg::MV_MIN;
            lo_reg <= wpd_pkg::MV_MAX;
        end else if (cmd.scan) begin
            if (win_reg[0] > hi_reg) begin
                hi_reg <= win_reg[0];
            end
            if (win_reg[0] < lo_reg) begin
                lo_reg <= win_reg[0];
            end
        end
    end

    // advance the window on update, rotate it once round during the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
            timer_reg <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.update) begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW_LEN-1] <= mv_reg;
                timer_reg             <= timer_next;
                count_reg             <= count_reg + 1'b1;
            end else if (cmd.scan) begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW_LEN-1] <= win_reg[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_mv_reg    <= mv_reg;
            out_peak_reg  <= hi_reg;
            out_dc_reg    <= !((hi_reg > 0) && (lo_reg < 0));
            out_timer_reg <= timer_reg;
            out_count_reg <= count_reg;
        end
    end

    assign status.out_full     = m_valid_reg;
    assign m_valid             = m_valid_reg;
    assign m_sample_mv         = out_mv_reg;
    assign m_peak_mv           = out_peak_reg;
    assign m_is_dc             = out_dc_reg;
    assign m_ms_since_crossing = out_timer_reg;
    assign m_sample_count      = out_count_reg;

endmodule
